@@ hdl/kf_pkg.sv @@
package kf_pkg;

    localparam int FRAC_BITS = 24;
    // width of an unsaturated rounded product and of the determinant
    localparam int MULW_W = 64 - FRAC_BITS;
    localparam int DET_W = MULW_W + 1;
    // scaled dividend magnitude and shifted divisor widths
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int DSH_W = DET_W + 32;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd56;

    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] P00_RESET = 32'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [31:0] P11_RESET = ONE_Q;
    localparam logic [30:0] QPOS_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [30:0] QVEL_RESET = 31'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [30:0] RPOS_RESET = 31'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [30:0] RVEL_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [2:0] CFG_QPOS = 3'd0;
    localparam logic [2:0] CFG_QVEL = 3'd1;
    localparam logic [2:0] CFG_RPOS = 3'd2;
    localparam logic [2:0] CFG_RVEL = 3'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        UOP_MUL,
        UOP_ADD,
        UOP_SUB,
        UOP_MULW,
        UOP_DET,
        UOP_DIV
    } uop_kind_t;

    typedef enum logic [5:0] {
        R_NONE, R_POS, R_VEL, R_C00, R_C01, R_C10, R_C11, R_DT, R_XP,
        R_P00, R_P01, R_P10, R_P11, R_Y0, R_Y1, R_S00, R_S11,
        R_I00, R_I01, R_I10, R_I11, R_K00, R_K01, R_K10, R_K11,
        R_A0, R_A1, R_T0, R_T1, R_PM, R_VM,
        R_QPOS, R_QVEL, R_RPOS, R_RVEL, R_ONE
    } reg_sel_t;

    typedef struct packed {
        uop_kind_t kind;
        reg_sel_t  dst;
        reg_sel_t  srca;
        reg_sel_t  srcb;
        logic      neg;
    } uop_t;

    function automatic uop_t mk(input uop_kind_t k, input reg_sel_t d,
                                input reg_sel_t a, input reg_sel_t b);
        uop_t u;
        u.kind = k;
        u.dst  = d;
        u.srca = a;
        u.srcb = b;
        u.neg  = 1'b0;
        return u;
    endfunction

    function automatic uop_t mkdiv(input reg_sel_t d, input reg_sel_t a, input logic n);
        uop_t u;
        u = mk(UOP_DIV, d, a, R_NONE);
        u.neg = n;
        return u;
    endfunction

    // microprogram of one update item
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            6'd0:  u = mk(UOP_MUL, R_T0, R_VEL, R_DT);
            6'd1:  u = mk(UOP_ADD, R_XP, R_POS, R_T0);
            6'd2:  u = mk(UOP_ADD, R_T0, R_C10, R_C01);
            6'd3:  u = mk(UOP_MUL, R_T0, R_DT, R_T0);
            6'd4:  u = mk(UOP_ADD, R_P00, R_C00, R_T0);
            6'd5:  u = mk(UOP_MUL, R_T0, R_DT, R_DT);
            6'd6:  u = mk(UOP_MUL, R_T0, R_T0, R_C11);
            6'd7:  u = mk(UOP_ADD, R_P00, R_P00, R_T0);
            6'd8:  u = mk(UOP_ADD, R_P00, R_P00, R_QPOS);
            6'd9:  u = mk(UOP_MUL, R_T0, R_DT, R_C11);
            6'd10: u = mk(UOP_ADD, R_P01, R_C01, R_T0);
            6'd11: u = mk(UOP_ADD, R_P10, R_C10, R_T0);
            6'd12: u = mk(UOP_ADD, R_P11, R_C11, R_QVEL);
            6'd13: u = mk(UOP_SUB, R_Y0, R_PM, R_XP);
            6'd14: u = mk(UOP_SUB, R_Y1, R_VM, R_VEL);
            6'd15: u = mk(UOP_ADD, R_S00, R_P00, R_RPOS);
            6'd16: u = mk(UOP_ADD, R_S11, R_P11, R_RVEL);
            6'd17: u = mk(UOP_MULW, R_NONE, R_S00, R_S11);
            6'd18: u = mk(UOP_DET, R_NONE, R_P01, R_P10);
            6'd19: u = mkdiv(R_I00, R_S11, 1'b0);
            6'd20: u = mkdiv(R_I01, R_P01, 1'b1);
            6'd21: u = mkdiv(R_I10, R_P10, 1'b1);
            6'd22: u = mkdiv(R_I11, R_S00, 1'b0);
            6'd23: u = mk(UOP_MUL, R_T0, R_P00, R_I00);
            6'd24: u = mk(UOP_MUL, R_T1, R_P01, R_I10);
            6'd25: u = mk(UOP_ADD, R_K00, R_T0, R_T1);
            6'd26: u = mk(UOP_MUL, R_T0, R_P00, R_I01);
            6'd27: u = mk(UOP_MUL, R_T1, R_P01, R_I11);
            6'd28: u = mk(UOP_ADD, R_K01, R_T0, R_T1);
            6'd29: u = mk(UOP_MUL, R_T0, R_P10, R_I00);
            6'd30: u = mk(UOP_MUL, R_T1, R_P11, R_I10);
            6'd31: u = mk(UOP_ADD, R_K10, R_T0, R_T1);
            6'd32: u = mk(UOP_MUL, R_T0, R_P10, R_I01);
            6'd33: u = mk(UOP_MUL, R_T1, R_P11, R_I11);
            6'd34: u = mk(UOP_ADD, R_K11, R_T0, R_T1);
            6'd35: u = mk(UOP_MUL, R_T0, R_K00, R_Y0);
            6'd36: u = mk(UOP_ADD, R_T0, R_XP, R_T0);
            6'd37: u = mk(UOP_MUL, R_T1, R_K01, R_Y1);
            6'd38: u = mk(UOP_ADD, R_POS, R_T0, R_T1);
            6'd39: u = mk(UOP_MUL, R_T0, R_K10, R_Y0);
            6'd40: u = mk(UOP_ADD, R_T0, R_VEL, R_T0);
            6'd41: u = mk(UOP_MUL, R_T1, R_K11, R_Y1);
            6'd42: u = mk(UOP_ADD, R_VEL, R_T0, R_T1);
            6'd43: u = mk(UOP_SUB, R_A0, R_ONE, R_K00);
            6'd44: u = mk(UOP_SUB, R_A1, R_ONE, R_K11);
            6'd45: u = mk(UOP_MUL, R_T0, R_A0, R_P00);
            6'd46: u = mk(UOP_MUL, R_T1, R_K01, R_P10);
            6'd47: u = mk(UOP_SUB, R_C00, R_T0, R_T1);
            6'd48: u = mk(UOP_MUL, R_T0, R_A0, R_P01);
            6'd49: u = mk(UOP_MUL, R_T1, R_K01, R_P11);
            6'd50: u = mk(UOP_SUB, R_C01, R_T0, R_T1);
            6'd51: u = mk(UOP_MUL, R_T0, R_A1, R_P10);
            6'd52: u = mk(UOP_MUL, R_T1, R_K10, R_P00);
            6'd53: u = mk(UOP_SUB, R_C10, R_T0, R_T1);
            6'd54: u = mk(UOP_MUL, R_T0, R_A1, R_P11);
            6'd55: u = mk(UOP_MUL, R_T1, R_K10, R_P01);
            6'd56: u = mk(UOP_SUB, R_C11, R_T0, R_T1);
            default: u = mk(UOP_ADD, R_NONE, R_NONE, R_NONE);
        endcase
        return u;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

@@ hdl/kf_div.sv @@
module kf_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [32:0]               num,
    input  logic signed [kf_pkg::DET_W-1:0]  den,
    output logic                             done,
    output logic [31:0]                      quot
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [5:0]                  cnt_reg;
    logic [kf_pkg::NUM_W-1:0]    rem_reg;
    logic [kf_pkg::DSH_W-1:0]    dsh_reg;
    logic [32:0]                 q_reg;
    logic                        neg_reg;

    logic [32:0]                 num_mag;
    logic [kf_pkg::DET_W-1:0]    den_mag;
    logic [kf_pkg::DSH_W-1:0]    rem_ext;
    logic                        ge;

    assign num_mag = num[32] ? 33'(-num) : 33'(num);
    assign den_mag = den[kf_pkg::DET_W-1] ? kf_pkg::DET_W'(-den) : kf_pkg::DET_W'(den);
    assign rem_ext = kf_pkg::DSH_W'(rem_reg);
    assign ge = rem_ext >= dsh_reg;

    // restoring divide on magnitudes, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            rem_reg <= kf_pkg::NUM_W'(num_mag[31:0]) << kf_pkg::FRAC_BITS;
            dsh_reg <= {den_mag, 32'b0};
            q_reg   <= '0;
            neg_reg <= num[32] ^ den[kf_pkg::DET_W-1];
        end
        else if (busy_reg)
        begin
            if (ge) rem_reg <= kf_pkg::NUM_W'(rem_ext - dsh_reg);
            q_reg   <= {q_reg[31:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // sign and saturation of the quotient
    always_comb begin
        if (!neg_reg)
            quot = (q_reg > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_reg[31:0];
        else
            quot = (q_reg > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-q_reg);
    end

    assign done = done_reg;

endmodule

@@ hdl/kalman_filter_pos_vel.sv @@
// Two-state constant-velocity Kalman filter in signed Q8.24. An init beat
// (op=1) loads position and velocity, resets the covariance and yields a
// result through the done state, once the output is free. An update beat
// (op=0) runs a 57-step microprogram on one shared multiplier, a saturating
// adder and a radix-2 divider: 27 multiply steps register a product and
// then use its rounded value, 26 add steps write at once, and 4 divisions
// wait for the bit-serial divider, which sets most of the run time. in_stall
// is high while an item is in work. Noise registers survive init beats; users
// write them through the cfg port while the block is idle, not enforced.
module kalman_filter_pos_vel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] pos_meas,
    input  logic signed [31:0] vel_meas,
    input  logic [23:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] est_pos,
    output logic signed [31:0] est_vel,
    output logic               singular,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    kf_pkg::state_t state_reg, state_next;
    logic [kf_pkg::STEP_W-1:0] step_reg, step_next;
    logic phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;

    logic [31:0] pos_reg, vel_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic [30:0] qpos_reg, qvel_reg, rpos_reg, rvel_reg;
    logic [31:0] dt_reg, pm_reg, vm_reg, xp_reg;
    logic [31:0] p00_reg, p01_reg, p10_reg, p11_reg, y0_reg, y1_reg, s00_reg, s11_reg;
    logic [31:0] i00_reg, i01_reg, i10_reg, i11_reg, k00_reg, k01_reg, k10_reg, k11_reg;
    logic [31:0] a0_reg, a1_reg, t0_reg, t1_reg;
    logic signed [63:0] prod_reg;
    logic signed [kf_pkg::MULW_W-1:0] dA_reg;
    logic signed [kf_pkg::DET_W-1:0] det_reg, det_next;
    logic sing_reg;
    logic [31:0] est_pos_reg, est_vel_reg;
    logic est_sing_reg;

    kf_pkg::uop_t uop;
    logic accept;
    logic signed [31:0] opa, opb;
    logic signed [63:0] rnd_sum;
    logic signed [kf_pkg::MULW_W-1:0] rw;
    logic [31:0] wr_val;
    logic wr_en, prod_en, dA_en, det_en, div_start, out_load;
    logic [55:0] dt_wide;
    logic signed [32:0] div_num;
    logic div_done;
    logic [31:0] div_quot;

    assign uop = kf_pkg::uop_at(step_reg);
    assign in_stall = (state_reg != kf_pkg::S_IDLE);
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign dt_wide = 56'(time_step) << kf_pkg::FRAC_BITS;

    // operand selection
    function automatic logic [31:0] pick(input kf_pkg::reg_sel_t s);
        logic [31:0] v;
        case (s)
            kf_pkg::R_POS:  v = pos_reg;
            kf_pkg::R_VEL:  v = vel_reg;
            kf_pkg::R_C00:  v = c00_reg;
            kf_pkg::R_C01:  v = c01_reg;
            kf_pkg::R_C10:  v = c10_reg;
            kf_pkg::R_C11:  v = c11_reg;
            kf_pkg::R_DT:   v = dt_reg;
            kf_pkg::R_XP:   v = xp_reg;
            kf_pkg::R_P00:  v = p00_reg;
            kf_pkg::R_P01:  v = p01_reg;
            kf_pkg::R_P10:  v = p10_reg;
            kf_pkg::R_P11:  v = p11_reg;
            kf_pkg::R_Y0:   v = y0_reg;
            kf_pkg::R_Y1:   v = y1_reg;
            kf_pkg::R_S00:  v = s00_reg;
            kf_pkg::R_S11:  v = s11_reg;
            kf_pkg::R_I00:  v = i00_reg;
            kf_pkg::R_I01:  v = i01_reg;
            kf_pkg::R_I10:  v = i10_reg;
            kf_pkg::R_I11:  v = i11_reg;
            kf_pkg::R_K00:  v = k00_reg;
            kf_pkg::R_K01:  v = k01_reg;
            kf_pkg::R_K10:  v = k10_reg;
            kf_pkg::R_K11:  v = k11_reg;
            kf_pkg::R_A0:   v = a0_reg;
            kf_pkg::R_A1:   v = a1_reg;
            kf_pkg::R_T0:   v = t0_reg;
            kf_pkg::R_T1:   v = t1_reg;
            kf_pkg::R_PM:   v = pm_reg;
            kf_pkg::R_VM:   v = vm_reg;
            kf_pkg::R_QPOS: v = {1'b0, qpos_reg};
            kf_pkg::R_QVEL: v = {1'b0, qvel_reg};
            kf_pkg::R_RPOS: v = {1'b0, rpos_reg};
            kf_pkg::R_RVEL: v = {1'b0, rvel_reg};
            kf_pkg::R_ONE:  v = kf_pkg::ONE_Q;
            default:        v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(uop.srca);
    assign opb = pick(uop.srcb);

    // product rounding, nearest with ties up
    assign rnd_sum = prod_reg + (64'sd1 <<< (kf_pkg::FRAC_BITS - 1));
    assign rw = kf_pkg::MULW_W'(rnd_sum >>> kf_pkg::FRAC_BITS);

    assign div_num = uop.neg ? -33'(opa) : 33'(opa);

    kf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (det_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        wr_val         = '0;
        prod_en        = 1'b0;
        dA_en          = 1'b0;
        det_en         = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        det_next       = kf_pkg::DET_W'(dA_reg) - kf_pkg::DET_W'(rw);
        case (state_reg)
            kf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = op ? kf_pkg::S_DONE : kf_pkg::S_RUN;
                end
            end
            kf_pkg::S_RUN:
            begin
                case (uop.kind)
                    kf_pkg::UOP_ADD:
                    begin
                        wr_en  = 1'b1;
                        wr_val = kf_pkg::sat32(64'(opa) + 64'(opb));
                    end
                    kf_pkg::UOP_SUB:
                    begin
                        wr_en  = 1'b1;
                        wr_val = kf_pkg::sat32(64'(opa) - 64'(opb));
                    end
                    kf_pkg::UOP_DIV:
                    begin
                        div_start = !phase_reg;
                        wr_en     = phase_reg && div_done;
                        wr_val    = div_quot;
                    end
                    default:
                    begin
                        prod_en = !phase_reg;
                        wr_en   = phase_reg && (uop.kind == kf_pkg::UOP_MUL);
                        wr_val  = kf_pkg::sat32(64'(rw));
                        dA_en   = phase_reg && (uop.kind == kf_pkg::UOP_MULW);
                        det_en  = phase_reg && (uop.kind == kf_pkg::UOP_DET);
                    end
                endcase
                if (uop.kind == kf_pkg::UOP_ADD || uop.kind == kf_pkg::UOP_SUB
                    || (phase_reg && (uop.kind != kf_pkg::UOP_DIV || div_done)))
                begin
                    phase_next = 1'b0;
                    if (step_reg == kf_pkg::LAST_STEP) state_next = kf_pkg::S_DONE;
                    else step_next = step_reg + 1'b1;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
            end
            kf_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = kf_pkg::S_IDLE;
                end
            end
            default: state_next = kf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= kf_pkg::S_IDLE;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // filter state, noise registers and singular flag
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            vel_reg  <= '0;
            c00_reg  <= kf_pkg::P00_RESET;
            c01_reg  <= '0;
            c10_reg  <= '0;
            c11_reg  <= kf_pkg::P11_RESET;
            qpos_reg <= kf_pkg::QPOS_RESET;
            qvel_reg <= kf_pkg::QVEL_RESET;
            rpos_reg <= kf_pkg::RPOS_RESET;
            rvel_reg <= kf_pkg::RVEL_RESET;
            sing_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    kf_pkg::CFG_QPOS: qpos_reg <= cfg_data[30:0];
                    kf_pkg::CFG_QVEL: qvel_reg <= cfg_data[30:0];
                    kf_pkg::CFG_RPOS: rpos_reg <= cfg_data[30:0];
                    kf_pkg::CFG_RVEL: rvel_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                sing_reg <= 1'b0;
                if (op)
                begin
                    pos_reg <= pos_meas;
                    vel_reg <= vel_meas;
                    c00_reg <= kf_pkg::P00_RESET;
                    c01_reg <= '0;
                    c10_reg <= '0;
                    c11_reg <= kf_pkg::P11_RESET;
                end
            end
            else if (det_en)
            begin
                sing_reg <= (det_next == '0);
            end
            else if (wr_en)
            begin
                case (uop.dst)
                    kf_pkg::R_POS: pos_reg <= wr_val;
                    kf_pkg::R_VEL: vel_reg <= wr_val;
                    kf_pkg::R_C00: c00_reg <= wr_val;
                    kf_pkg::R_C01: c01_reg <= wr_val;
                    kf_pkg::R_C10: c10_reg <= wr_val;
                    kf_pkg::R_C11: c11_reg <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    // working registers of one update and the output registers
    always_ff @(posedge clk) begin
        if (accept)
        begin
            pm_reg <= pos_meas;
            vm_reg <= vel_meas;
            dt_reg <= dt_wide[24 +: 32];
        end
        if (prod_en) prod_reg <= 64'(opa) * 64'(opb);
        if (dA_en) dA_reg <= rw;
        if (det_en) det_reg <= (det_next == '0) ? kf_pkg::DET_W'(1) : det_next;
        if (wr_en)
        begin
            case (uop.dst)
                kf_pkg::R_XP:  xp_reg  <= wr_val;
                kf_pkg::R_P00: p00_reg <= wr_val;
                kf_pkg::R_P01: p01_reg <= wr_val;
                kf_pkg::R_P10: p10_reg <= wr_val;
                kf_pkg::R_P11: p11_reg <= wr_val;
                kf_pkg::R_Y0:  y0_reg  <= wr_val;
                kf_pkg::R_Y1:  y1_reg  <= wr_val;
                kf_pkg::R_S00: s00_reg <= wr_val;
                kf_pkg::R_S11: s11_reg <= wr_val;
                kf_pkg::R_I00: i00_reg <= wr_val;
                kf_pkg::R_I01: i01_reg <= wr_val;
                kf_pkg::R_I10: i10_reg <= wr_val;
                kf_pkg::R_I11: i11_reg <= wr_val;
                kf_pkg::R_K00: k00_reg <= wr_val;
                kf_pkg::R_K01: k01_reg <= wr_val;
                kf_pkg::R_K10: k10_reg <= wr_val;
                kf_pkg::R_K11: k11_reg <= wr_val;
                kf_pkg::R_A0:  a0_reg  <= wr_val;
                kf_pkg::R_A1:  a1_reg  <= wr_val;
                kf_pkg::R_T0:  t0_reg  <= wr_val;
                kf_pkg::R_T1:  t1_reg  <= wr_val;
                default: ;
            endcase
        end
        if (out_load)
        begin
            est_pos_reg  <= pos_reg;
            est_vel_reg  <= vel_reg;
            est_sing_reg <= sing_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign est_pos   = est_pos_reg;
    assign est_vel   = est_vel_reg;
    assign singular  = est_sing_reg;

    // checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kf_pkg::S_RUN |-> step_reg <= kf_pkg::LAST_STEP)
        else $error("microprogram step out of range");

    a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> det_reg != '0)
        else $error("divider started with zero determinant");

    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kf_pkg::S_RUN && sing_reg) |-> det_reg == kf_pkg::DET_W'(1))
        else $error("singular flag without replaced determinant");

    a_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != kf_pkg::S_IDLE)
        else $error("accepted beat did not start work");

endmodule
